### hw/rtl/lfslt_pkg.sv
package lfslt_pkg;

    // Default width of the internal steer amount registers.
    localparam int AMOUNT_BITS_DEF = 16;

    // Configuration register file.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    localparam logic [REG_IDX_W-1:0] REG_LEFT_DECAY        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_DECAY       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_SLIGHT_STEP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_SLIGHT_STEP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_STRONG_STEP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_STRONG_STEP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_LIMIT        = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_LIMIT       = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [REG_COUNT] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF
    };

    // Motion command codes.
    localparam logic [1:0] MOTION_NONE  = 2'd0;
    localparam logic [1:0] MOTION_STOP  = 2'd1;
    localparam logic [1:0] MOTION_START = 2'd2;

    // Speed code = floor(moving * SPEED_SCALE / lap); never above SPEED_SCALE.
    localparam int SPEED_SCALE = 105;
    localparam int QUOT_BITS   = 7;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int ADD_W     = 16;
    localparam int OUT_AMT_W = 16;
    localparam int SPEED_W   = 16;
    localparam int COUNT_W   = 16;

    // Request payload layout (53 bits used, padded to 56).
    localparam int IN_TDATA_W    = 56;
    localparam int IN_RUN_BIT    = 0;
    localparam int IN_OBST_BIT   = 1;
    localparam int IN_LEFT_BIT   = 2;
    localparam int IN_MIDDLE_BIT = 3;
    localparam int IN_RIGHT_BIT  = 4;
    localparam int IN_NOW_LSB    = 5;
    localparam int IN_ADD_LSB    = 37;

    // Result payload layout (101 bits used, padded to 104).
    localparam int OUT_TDATA_W    = 104;
    localparam int OUT_CMD_LSB    = 0;
    localparam int OUT_LV_BIT     = 2;
    localparam int OUT_LA_LSB     = 3;
    localparam int OUT_RV_BIT     = 19;
    localparam int OUT_RA_LSB     = 20;
    localparam int OUT_LAPEV_BIT  = 36;
    localparam int OUT_LAPT_LSB   = 37;
    localparam int OUT_SPEED_LSB  = 69;
    localparam int OUT_LAPS_LSB   = 85;

endpackage

### hw/rtl/line_follow_steer_lap_timer_unit.sv
// Sequence: a request without a lap report passes S_EVAL and S_FINISH; a completed lap
//   adds difference, scale and 7 divide steps before the load; a zero-length lap skips the divide.
// Flow: one request at a time; the next is accepted only once the result is loaded, which waits
//   while the sink stalls the held result. The divide loop runs on the shared compare/subtract unit.
// Reset: i_rst_n synchronous, active low; clears sequencer, run/lap state, steer amounts
//   and counters, and loads register defaults (decays and steps 0, limits 65535).
module line_follow_steer_lap_timer_unit #(
    parameter int AMOUNT_BITS = lfslt_pkg::AMOUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: run_request[0], obstacle[1], left_black[2], middle_black[3],
    //        right_black[4], now_ms[36:5], stopped_add[52:37], zero pad[55:53]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lfslt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tdata: motion_cmd[1:0], steer_left_valid[2], steer_left_amount[18:3],
    //        steer_right_valid[19], steer_right_amount[35:20], lap_event[36],
    //        lap_time_ms[68:37], lap_speed_code[84:69], laps_done[100:85], pad[103:101]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lfslt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfslt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfslt_pkg::CFG_W-1:0]         i_cfg_data
);
    import lfslt_pkg::*;

    // Common width for amount/register compares and sums.
    localparam int CW     = (AMOUNT_BITS > CFG_W) ? AMOUNT_BITS : CFG_W;
    localparam int PROD_W = TIME_W + QUOT_BITS;
    localparam int ALU_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(QUOT_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOVE,
        S_MUL,
        S_DIV,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DIR_FORWARD = 2'd0,
        DIR_LEFT    = 2'd1,
        DIR_RIGHT   = 2'd2
    } t_dir;

    // Add a step to an amount and clamp the sum to the limit.
    function automatic logic [AMOUNT_BITS-1:0] step_clamp(
        input logic [AMOUNT_BITS-1:0] amt,
        input logic [CFG_W-1:0]       stp,
        input logic [CFG_W-1:0]       lim
    );
        logic [CW:0] sum;
        sum = (CW+1)'(amt) + (CW+1)'(stp);
        if (sum > (CW+1)'(lim)) begin
            sum = (CW+1)'(lim);
        end
        return sum[AMOUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_AMT_W-1:0] to_out(input logic [AMOUNT_BITS-1:0] amt);
        logic [CW-1:0] ext;
        ext = CW'(amt);
        return ext[OUT_AMT_W-1:0];
    endfunction

    // Configuration registers, each read at a fixed place.
    logic [CFG_W-1:0] r_cfg [REG_COUNT];

    // Sequencer and item state.
    t_state                  r_state, n_state;
    logic                    r_moving, n_moving;
    logic                    r_in_lap, n_in_lap;
    logic                    r_lap_done, n_lap_done;
    t_dir                    r_dir, n_dir;
    logic [AMOUNT_BITS-1:0]  r_left_amt, n_left_amt;
    logic [AMOUNT_BITS-1:0]  r_right_amt, n_right_amt;
    logic [TIME_W-1:0]       r_lap_start, n_lap_start;
    logic [TIME_W-1:0]       r_stopped, n_stopped;
    logic [COUNT_W-1:0]      r_laps, n_laps;
    logic                    r_out_valid, n_out_valid;

    // Captured request fields.
    logic                    r_run, r_obst, r_lb, r_mb, r_rb;
    logic [TIME_W-1:0]       r_now;
    logic [ADD_W-1:0]        r_add;

    // Per-item results and divide working registers.
    logic [1:0]              r_cmd, n_cmd;
    logic                    r_lv, n_lv;
    logic [OUT_AMT_W-1:0]    r_la, n_la;
    logic                    r_rv, n_rv;
    logic [OUT_AMT_W-1:0]    r_ra, n_ra;
    logic                    r_lap_ev, n_lap_ev;
    logic [TIME_W-1:0]       r_lap_ms, n_lap_ms;
    logic [TIME_W-1:0]       r_acc, n_acc;
    logic [PROD_W-1:0]       r_rem, n_rem;
    logic [PROD_W-1:0]       r_dvs, n_dvs;
    logic [QUOT_BITS-1:0]    r_quot, n_quot;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [OUT_TDATA_W-1:0]  r_out_tdata, n_out_tdata;

    // Shared compare/subtract unit.
    logic [ALU_W-1:0]        alu_a, alu_b, alu_diff;
    logic                    alu_borrow;

    logic                    lap_mark;
    logic [TIME_W-1:0]       lap_start_e;
    logic [TIME_W-1:0]       stopped_e;
    logic [CW-1:0]           dec_diff_l, dec_diff_r;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign o_cfg_ready   = 1'b1;

    // Operands: lap time minus stopped ticks, or remainder minus shifted divisor.
    always_comb begin
        if (r_state == S_DIV) begin
            alu_a = {1'b0, r_rem};
            alu_b = {1'b0, r_dvs};
        end else begin
            alu_a = ALU_W'(r_lap_ms);
            alu_b = ALU_W'(r_acc);
        end
        alu_diff   = alu_a - alu_b;
        alu_borrow = alu_diff[ALU_W-1];
    end

    assign dec_diff_l = CW'(r_left_amt) - CW'(r_cfg[REG_LEFT_DECAY]);
    assign dec_diff_r = CW'(r_right_amt) - CW'(r_cfg[REG_RIGHT_DECAY]);

    always_comb begin
        n_state     = r_state;
        n_moving    = r_moving;
        n_in_lap    = r_in_lap;
        n_lap_done  = r_lap_done;
        n_dir       = r_dir;
        n_left_amt  = r_left_amt;
        n_right_amt = r_right_amt;
        n_lap_start = r_lap_start;
        n_stopped   = r_stopped;
        n_laps      = r_laps;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_lv        = r_lv;
        n_la        = r_la;
        n_rv        = r_rv;
        n_ra        = r_ra;
        n_lap_ev    = r_lap_ev;
        n_lap_ms    = r_lap_ms;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quot      = r_quot;
        n_step      = r_step;
        n_out_tdata = r_out_tdata;
        lap_mark    = 1'b0;
        lap_start_e = r_in_lap ? r_lap_start : r_now;
        stopped_e   = r_in_lap ? (r_stopped + TIME_W'(r_add)) : '0;

        // drop the held result once the sink takes it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                n_cmd      = MOTION_NONE;
                n_lv       = 1'b0;
                n_la       = '0;
                n_rv       = 1'b0;
                n_ra       = '0;
                n_lap_ev   = 1'b0;
                n_lap_ms   = '0;
                n_quot     = '0;
                n_stopped  = r_stopped + TIME_W'(r_add);
                n_state    = S_FINISH;
                if (!r_run || r_obst) begin
                    // stop request: the motor command changes and stopped ticks accumulate
                    if (r_moving) begin
                        n_cmd    = MOTION_STOP;
                        n_moving = 1'b0;
                    end
                end else begin
                    if (!r_moving) begin
                        n_cmd    = MOTION_START;
                        n_moving = 1'b1;
                    end
                    n_in_lap    = 1'b1;
                    n_lap_start = lap_start_e;
                    n_stopped   = stopped_e;
                    unique case ({r_lb, r_mb, r_rb})
                        3'b111: begin
                            // on track: decay both sides
                            n_lap_done = 1'b0;
                            n_dir      = DIR_FORWARD;
                            if (CW'(r_left_amt) < CW'(r_cfg[REG_LEFT_DECAY])) begin
                                n_left_amt = '0;
                            end else begin
                                n_left_amt = dec_diff_l[AMOUNT_BITS-1:0];
                                n_lv       = 1'b1;
                                n_la       = to_out(dec_diff_l[AMOUNT_BITS-1:0]);
                            end
                            if (CW'(r_right_amt) < CW'(r_cfg[REG_RIGHT_DECAY])) begin
                                n_right_amt = '0;
                            end else begin
                                n_right_amt = dec_diff_r[AMOUNT_BITS-1:0];
                                n_rv        = 1'b1;
                                n_ra        = to_out(dec_diff_r[AMOUNT_BITS-1:0]);
                            end
                        end
                        3'b011: begin
                            n_left_amt  = '0;
                            n_right_amt = step_clamp(r_right_amt,
                                r_cfg[REG_RIGHT_SLIGHT_STEP], r_cfg[REG_RIGHT_LIMIT]);
                            n_rv        = 1'b1;
                            n_ra        = to_out(n_right_amt);
                            n_dir       = DIR_RIGHT;
                        end
                        3'b001: begin
                            if (r_dir == DIR_RIGHT) begin
                                n_left_amt  = '0;
                                n_right_amt = step_clamp(r_right_amt,
                                    r_cfg[REG_RIGHT_STRONG_STEP], r_cfg[REG_RIGHT_LIMIT]);
                                n_rv        = 1'b1;
                                n_ra        = to_out(n_right_amt);
                            end else if (r_dir == DIR_FORWARD) begin
                                lap_mark = 1'b1;
                            end
                        end
                        3'b000: begin
                            lap_mark = 1'b1;
                        end
                        3'b110: begin
                            n_right_amt = '0;
                            n_left_amt  = step_clamp(r_left_amt,
                                r_cfg[REG_LEFT_SLIGHT_STEP], r_cfg[REG_LEFT_LIMIT]);
                            n_lv        = 1'b1;
                            n_la        = to_out(n_left_amt);
                            n_dir       = DIR_LEFT;
                        end
                        3'b100: begin
                            if (r_dir == DIR_LEFT) begin
                                n_right_amt = '0;
                                n_left_amt  = step_clamp(r_left_amt,
                                    r_cfg[REG_LEFT_STRONG_STEP], r_cfg[REG_LEFT_LIMIT]);
                                n_lv        = 1'b1;
                                n_la        = to_out(n_left_amt);
                            end else if (r_dir == DIR_FORWARD) begin
                                lap_mark = 1'b1;
                            end
                        end
                        default: begin
                            // lone middle, or both edges without middle: hold steering
                        end
                    endcase

                    if (lap_mark && !r_lap_done) begin
                        // report the lap and open the next one
                        n_lap_ev    = 1'b1;
                        n_lap_ms    = r_now - lap_start_e;
                        n_acc       = stopped_e;
                        n_lap_start = r_now;
                        n_stopped   = '0;
                        n_lap_done  = 1'b1;
                        n_laps      = r_laps + COUNT_W'(1);
                        n_state     = S_MOVE;
                    end
                end
            end

            S_MOVE: begin
                // moving time, clamped at zero
                n_acc   = alu_borrow ? '0 : alu_diff[TIME_W-1:0];
                n_state = S_MUL;
            end

            S_MUL: begin
                n_rem   = PROD_W'(r_acc) * PROD_W'(SPEED_SCALE);
                n_dvs   = PROD_W'(r_lap_ms) << (QUOT_BITS - 1);
                n_step  = STEP_W'(QUOT_BITS - 1);
                n_quot  = '0;
                n_state = (r_lap_ms == '0) ? S_FINISH : S_DIV;
            end

            S_DIV: begin
                // one quotient bit per cycle, most significant first
                if (!alu_borrow) begin
                    n_rem = alu_diff[PROD_W-1:0];
                end
                n_quot = {r_quot[QUOT_BITS-2:0], ~alu_borrow};
                n_dvs  = r_dvs >> 1;
                if (r_step == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end

            S_FINISH: begin
                // load the output register once it is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_tdata = '0;
                    n_out_tdata[OUT_CMD_LSB +: 2]          = r_cmd;
                    n_out_tdata[OUT_LV_BIT]                = r_lv;
                    n_out_tdata[OUT_LA_LSB +: OUT_AMT_W]   = r_la;
                    n_out_tdata[OUT_RV_BIT]                = r_rv;
                    n_out_tdata[OUT_RA_LSB +: OUT_AMT_W]   = r_ra;
                    n_out_tdata[OUT_LAPEV_BIT]             = r_lap_ev;
                    n_out_tdata[OUT_LAPT_LSB +: TIME_W]    = r_lap_ms;
                    n_out_tdata[OUT_SPEED_LSB +: SPEED_W]  = SPEED_W'(r_quot);
                    n_out_tdata[OUT_LAPS_LSB +: COUNT_W]   = r_laps;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // payload: no reset needed
        if (s_axis_tvalid && s_axis_tready) begin
            r_run <= s_axis_tdata[IN_RUN_BIT];
            r_obst <= s_axis_tdata[IN_OBST_BIT];
            r_lb <= s_axis_tdata[IN_LEFT_BIT];
            r_mb <= s_axis_tdata[IN_MIDDLE_BIT];
            r_rb <= s_axis_tdata[IN_RIGHT_BIT];
            r_now <= s_axis_tdata[IN_NOW_LSB +: TIME_W];
            r_add <= s_axis_tdata[IN_ADD_LSB +: ADD_W];
        end
        r_cmd       <= n_cmd;
        r_lv        <= n_lv;
        r_la        <= n_la;
        r_rv        <= n_rv;
        r_ra        <= n_ra;
        r_lap_ev    <= n_lap_ev;
        r_lap_ms    <= n_lap_ms;
        r_acc       <= n_acc;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_quot      <= n_quot;
        r_step      <= n_step;
        r_out_tdata <= n_out_tdata;

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_moving    <= 1'b0;
            r_in_lap    <= 1'b0;
            r_lap_done  <= 1'b1;
            r_dir       <= DIR_FORWARD;
            r_left_amt  <= '0;
            r_right_amt <= '0;
            r_lap_start <= '0;
            r_stopped   <= '0;
            r_laps      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else begin
            r_state     <= n_state;
            r_moving    <= n_moving;
            r_in_lap    <= n_in_lap;
            r_lap_done  <= n_lap_done;
            r_dir       <= n_dir;
            r_left_amt  <= n_left_amt;
            r_right_amt <= n_right_amt;
            r_lap_start <= n_lap_start;
            r_stopped   <= n_stopped;
            r_laps      <= n_laps;
            r_out_valid <= n_out_valid;
            // ignore writes beyond the register list
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
                r_cfg[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

endmodule

### hw/rtl/lfslt_checker.sv
module lfslt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lfslt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lfslt_pkg::*;

    logic [1:0]          cmd;
    logic                lap_ev;
    logic [TIME_W-1:0]   lap_ms;
    logic [SPEED_W-1:0]  speed;

    assign cmd      = m_axis_tdata[OUT_CMD_LSB +: 2];
    assign lap_ev   = m_axis_tdata[OUT_LAPEV_BIT];
    assign lap_ms   = m_axis_tdata[OUT_LAPT_LSB +: TIME_W];
    assign speed    = m_axis_tdata[OUT_SPEED_LSB +: SPEED_W];

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (cmd == MOTION_NONE) || (cmd == MOTION_STOP) || (cmd == MOTION_START))
        else $error("undefined motion command");

    a_no_lap_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !lap_ev |-> (lap_ms == '0) && (speed == '0))
        else $error("lap fields set without a lap");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && lap_ev |-> speed <= SPEED_W'(SPEED_SCALE))
        else $error("speed code out of range");

endmodule

bind line_follow_steer_lap_timer_unit lfslt_checker u_lfslt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/line_follow_steer_lap_timer_unit_tb.sv
module line_follow_steer_lap_timer_unit_tb;

    import lfslt_pkg::*;

    // Allow roughly four times the slowest legal run: each request can see the
    // longest send gap, a lap report and the longest result stall.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Let a lap report (the longest path) drain before touching registers.
    localparam int SETTLE_CYCLES = 16;

    // Indexes past the register file; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_COUNT);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // Line sensor patterns, packed as {left, middle, right}, 1 = black.
    localparam logic [2:0] SENSE_ALL_BLACK    = 3'b111;
    localparam logic [2:0] SENSE_SLIGHT_RIGHT = 3'b011;
    localparam logic [2:0] SENSE_STRONG_RIGHT = 3'b001;
    localparam logic [2:0] SENSE_SLIGHT_LEFT  = 3'b110;
    localparam logic [2:0] SENSE_STRONG_LEFT  = 3'b100;
    localparam logic [2:0] SENSE_ALL_WHITE    = 3'b000;
    localparam logic [2:0] SENSE_MIDDLE_ONLY  = 3'b010;
    localparam logic [2:0] SENSE_OUTER_ONLY   = 3'b101;

    typedef enum logic [1:0] {
        HEAD_FORWARD = 2'd0,
        HEAD_LEFT    = 2'd1,
        HEAD_RIGHT   = 2'd2
    } t_heading;

    // Request payload, last declared field in the lowest bits.
    typedef struct packed {
        logic [ADD_W-1:0]  stopped_add;
        logic [TIME_W-1:0] now_ms;
        logic              right_black;
        logic              middle_black;
        logic              left_black;
        logic              obstacle;
        logic              run_request;
    } t_sample;

    // Result payload, last declared field in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0]   laps_done;
        logic [SPEED_W-1:0]   speed_code;
        logic [TIME_W-1:0]    lap_ms;
        logic                 lap_event;
        logic [OUT_AMT_W-1:0] right_amount;
        logic                 right_valid;
        logic [OUT_AMT_W-1:0] left_amount;
        logic                 left_valid;
        logic [1:0]           motion_cmd;
    } t_outcome;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid    = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;

    line_follow_steer_lap_timer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow of the block: register file plus run, lap and steering state.
    logic [CFG_W-1:0]     cfg_model [REG_COUNT];
    logic                 moving_m      = 1'b0;
    logic                 in_lap_m      = 1'b0;
    logic                 lap_done_m    = 1'b1;
    t_heading             heading_m     = HEAD_FORWARD;
    logic [OUT_AMT_W-1:0] left_amt_m    = '0;
    logic [OUT_AMT_W-1:0] right_amt_m   = '0;
    logic [TIME_W-1:0]    lap_start_m   = '0;
    logic [TIME_W-1:0]    stopped_m     = '0;
    logic [COUNT_W-1:0]   laps_m        = '0;

    t_sample  sample_q[$];            // requests waiting for the driver
    t_outcome expected_outcomes[$];   // predicted results, oldest first

    int  cycle_cnt     = 0;
    int  mismatch_cnt  = 0;
    int  samples_taken = 0;
    int  lap_reports   = 0;
    int  start_cmds    = 0;
    int  stop_cmds     = 0;
    int  veer_cmds     = 0;
    int  cfg_writes    = 0;
    int  settings_used = 1;
    int  send_gap      = 0;
    int  recv_stall    = 0;
    bit  req_taken     = 1'b0;
    bit  steady_flow   = 1'b0;
    logic [TIME_W-1:0] track_ms = 32'hFFF0_0000;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either handshake.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly no delay, often a short one, now and then a long one.
    function automatic int pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OUT_AMT_W-1:0] raise_clamped(
        input logic [OUT_AMT_W-1:0] amount,
        input logic [CFG_W-1:0]     step,
        input logic [CFG_W-1:0]     limit
    );
        logic [OUT_AMT_W:0] sum;
        sum = {1'b0, amount} + {1'b0, step};
        return (sum > {1'b0, limit}) ? limit : sum[OUT_AMT_W-1:0];
    endfunction

    // Advance the shadow state by one sample and return the result it owes.
    function automatic t_outcome steer_lap_step(input t_sample s);
        t_outcome          o;
        logic              lap_mark;
        logic [TIME_W-1:0] lap_len;
        logic [TIME_W-1:0] moving_len;
        o        = '0;
        lap_mark = 1'b0;
        // Stopped ticks accumulate first, whatever else the sample does.
        stopped_m = stopped_m + TIME_W'(s.stopped_add);
        if (!s.run_request || s.obstacle) begin
            if (moving_m) begin
                o.motion_cmd = MOTION_STOP;
                moving_m     = 1'b0;
            end
        end else begin
            if (!moving_m) begin
                o.motion_cmd = MOTION_START;
                moving_m     = 1'b1;
            end
            if (!in_lap_m) begin
                lap_start_m = s.now_ms;
                stopped_m   = '0;
                in_lap_m    = 1'b1;
            end
            case ({s.left_black, s.middle_black, s.right_black})
                SENSE_ALL_BLACK: begin
                    // On track: arm the lap mark and let both amounts decay.
                    lap_done_m = 1'b0;
                    heading_m  = HEAD_FORWARD;
                    if (left_amt_m < cfg_model[REG_LEFT_DECAY]) begin
                        left_amt_m = '0;
                    end else begin
                        left_amt_m    = left_amt_m - cfg_model[REG_LEFT_DECAY];
                        o.left_valid  = 1'b1;
                        o.left_amount = left_amt_m;
                    end
                    if (right_amt_m < cfg_model[REG_RIGHT_DECAY]) begin
                        right_amt_m = '0;
                    end else begin
                        right_amt_m    = right_amt_m - cfg_model[REG_RIGHT_DECAY];
                        o.right_valid  = 1'b1;
                        o.right_amount = right_amt_m;
                    end
                end
                SENSE_SLIGHT_RIGHT: begin
                    left_amt_m     = '0;
                    right_amt_m    = raise_clamped(right_amt_m,
                                                   cfg_model[REG_RIGHT_SLIGHT_STEP],
                                                   cfg_model[REG_RIGHT_LIMIT]);
                    o.right_valid  = 1'b1;
                    o.right_amount = right_amt_m;
                    heading_m      = HEAD_RIGHT;
                end
                SENSE_STRONG_RIGHT: begin
                    // Keep turning if already turning right; from straight
                    // ahead this pattern is a lap mark.
                    if (heading_m == HEAD_RIGHT) begin
                        left_amt_m     = '0;
                        right_amt_m    = raise_clamped(right_amt_m,
                                                       cfg_model[REG_RIGHT_STRONG_STEP],
                                                       cfg_model[REG_RIGHT_LIMIT]);
                        o.right_valid  = 1'b1;
                        o.right_amount = right_amt_m;
                    end else if (heading_m == HEAD_FORWARD) begin
                        lap_mark = 1'b1;
                    end
                end
                SENSE_SLIGHT_LEFT: begin
                    right_amt_m   = '0;
                    left_amt_m    = raise_clamped(left_amt_m,
                                                  cfg_model[REG_LEFT_SLIGHT_STEP],
                                                  cfg_model[REG_LEFT_LIMIT]);
                    o.left_valid  = 1'b1;
                    o.left_amount = left_amt_m;
                    heading_m     = HEAD_LEFT;
                end
                SENSE_STRONG_LEFT: begin
                    if (heading_m == HEAD_LEFT) begin
                        right_amt_m   = '0;
                        left_amt_m    = raise_clamped(left_amt_m,
                                                      cfg_model[REG_LEFT_STRONG_STEP],
                                                      cfg_model[REG_LEFT_LIMIT]);
                        o.left_valid  = 1'b1;
                        o.left_amount = left_amt_m;
                    end else if (heading_m == HEAD_FORWARD) begin
                        lap_mark = 1'b1;
                    end
                end
                SENSE_ALL_WHITE: begin
                    lap_mark = 1'b1;
                end
                default: begin
                    // Middle only or both outer sensors: hold steering.
                end
            endcase
            if (lap_mark && !lap_done_m) begin
                lap_len    = s.now_ms - lap_start_m;
                moving_len = (stopped_m > lap_len) ? '0 : lap_len - stopped_m;
                o.lap_event  = 1'b1;
                o.lap_ms     = lap_len;
                o.speed_code = (lap_len == '0) ? '0 :
                    SPEED_W'((64'(moving_len) * SPEED_SCALE) / 64'(lap_len));
                lap_start_m = s.now_ms;
                stopped_m   = '0;
                lap_done_m  = 1'b1;
                laps_m      = laps_m + 1'b1;
            end
        end
        o.laps_done = laps_m;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("cycle %0d: %s mismatch, got 0x%0h, want 0x%0h",
                     cycle_cnt, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Driver: present the next request at the falling edge once the previous
    // one was taken and the random gap has run out.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                s_axis_tdata  <= IN_TDATA_W'(sample_q.pop_front());
                s_axis_tvalid <= 1'b1;
                send_gap = pick_delay();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure: stall the output between accepts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_delay();
            end
        end
    end

    // Monitor: predict on every accepted request, then check every result
    // against the oldest prediction. Predicting first keeps this edge-safe.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = steer_lap_step(t_sample'(s_axis_tdata[$bits(t_sample)-1:0]));
                expected_outcomes.push_back(want);
                req_taken = 1'b1;
                samples_taken++;
                lap_reports += want.lap_event;
                start_cmds  += (want.motion_cmd == MOTION_START);
                stop_cmds   += (want.motion_cmd == MOTION_STOP);
                veer_cmds   += want.left_valid + want.right_valid;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_outcome'(m_axis_tdata[$bits(t_outcome)-1:0]);
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unrequested result, laps_done", got.laps_done, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("motion_cmd",         got.motion_cmd,   want.motion_cmd);
                    check_field("steer_left_valid",   got.left_valid,   want.left_valid);
                    check_field("steer_left_amount",  got.left_amount,  want.left_amount);
                    check_field("steer_right_valid",  got.right_valid,  want.right_valid);
                    check_field("steer_right_amount", got.right_amount, want.right_amount);
                    check_field("lap_event",          got.lap_event,    want.lap_event);
                    check_field("lap_time_ms",        got.lap_ms,       want.lap_ms);
                    check_field("lap_speed_code",     got.speed_code,   want.speed_code);
                    check_field("laps_done",          got.laps_done,    want.laps_done);
                end
            end
        end
    end

    function automatic void queue_sample(input logic run, input logic obstacle,
                                         input logic [2:0] pattern,
                                         input logic [TIME_W-1:0] now,
                                         input logic [ADD_W-1:0] add);
        t_sample s;
        s.run_request  = run;
        s.obstacle     = obstacle;
        s.left_black   = pattern[2];
        s.middle_black = pattern[1];
        s.right_black  = pattern[0];
        s.now_ms       = now;
        s.stopped_add  = add;
        sample_q.push_back(s);
    endfunction

    // Mostly laps driven over a plausible track with a rising clock, some
    // stop and obstacle samples, and a tenth pure noise.
    task automatic queue_track(input int count);
        int           roll;
        int           dt;
        logic [2:0]   pattern;
        logic [ADD_W-1:0] add;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                queue_sample(1'($urandom), 1'($urandom), 3'($urandom),
                             $urandom, ADD_W'($urandom));
            end else begin
                dt = $urandom_range(0, 99);
                dt = (dt < 10) ? 0 :
                     (dt < 85) ? $urandom_range(1, 40) :
                     (dt < 97) ? $urandom_range(41, 2000) : $urandom_range(2001, 100000);
                track_ms = track_ms + TIME_W'(dt);
                add = ADD_W'($urandom_range(0, 99));
                add = (add < 70) ? '0 :
                      (add < 95) ? ADD_W'($urandom_range(0, dt)) : ADD_W'($urandom);
                if (roll < 22) begin
                    // Halt: either no run request or something in the way.
                    if ($urandom_range(0, 1))
                        queue_sample(1'b0, 1'($urandom), 3'($urandom), track_ms, add);
                    else
                        queue_sample(1'b1, 1'b1, 3'($urandom), track_ms, add);
                end else begin
                    roll = $urandom_range(0, 99);
                    pattern = (roll < 30) ? SENSE_ALL_BLACK :
                              (roll < 43) ? SENSE_SLIGHT_RIGHT :
                              (roll < 56) ? SENSE_SLIGHT_LEFT :
                              (roll < 68) ? SENSE_STRONG_RIGHT :
                              (roll < 80) ? SENSE_STRONG_LEFT :
                              (roll < 90) ? SENSE_ALL_WHITE :
                              (roll < 95) ? SENSE_MIDDLE_ONLY : SENSE_OUTER_ONLY;
                    queue_sample(1'b1, 1'b0, pattern, track_ms, add);
                end
            end
        end
    endtask

    // Hold until nothing is queued, in flight or owed, then let the block settle.
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx < REG_COUNT)
            cfg_model[idx[REG_IDX_W-1:0]] = val;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] l_decay, r_decay,
                                 l_slight, r_slight, l_strong, r_strong,
                                 l_limit, r_limit);
        write_reg(REG_LEFT_DECAY,        l_decay);
        write_reg(REG_RIGHT_DECAY,       r_decay);
        write_reg(REG_LEFT_SLIGHT_STEP,  l_slight);
        write_reg(REG_RIGHT_SLIGHT_STEP, r_slight);
        write_reg(REG_LEFT_STRONG_STEP,  l_strong);
        write_reg(REG_RIGHT_STRONG_STEP, r_strong);
        write_reg(REG_LEFT_LIMIT,        l_limit);
        write_reg(REG_RIGHT_LIMIT,       r_limit);
        settings_used++;
    endtask

    initial begin
        cfg_model = CFG_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Run on the power-up register values first.
        queue_track(150);
        wait_idle();

        // Moderate steps and limits so clamping is reached in a few samples;
        // the spare indexes must not disturb anything.
        apply_setting(16'd3, 16'd5, 16'd40, 16'd60, 16'd200, 16'd300,
                      16'd1000, 16'd900);
        write_reg(REG_SPARE_LO, 16'h1234);
        write_reg(REG_SPARE_HI, 16'hFFFF);

        // Directed walk over every sensor case.
        queue_sample(1'b0, 1'b0, SENSE_ALL_BLACK,    32'd10,  16'd0);     // idle stop
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'd100, 16'd0);     // start, arm lap
        queue_sample(1'b1, 1'b0, SENSE_SLIGHT_RIGHT, 32'd110, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_STRONG_RIGHT, 32'd120, 16'd0);     // keep turning
        queue_sample(1'b1, 1'b0, SENSE_STRONG_RIGHT, 32'd130, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_STRONG_RIGHT, 32'd140, 16'd0);     // hits the limit
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'd160, 16'd0);     // decay
        queue_sample(1'b1, 1'b0, SENSE_STRONG_RIGHT, 32'd170, 16'd7);     // lap from straight
        queue_sample(1'b1, 1'b0, SENSE_ALL_WHITE,    32'd180, 16'd0);     // lap already taken
        queue_sample(1'b1, 1'b0, SENSE_SLIGHT_LEFT,  32'd190, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_STRONG_LEFT,  32'd200, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'd210, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_STRONG_LEFT,  32'd230, 16'd0);     // lap from straight
        queue_sample(1'b1, 1'b0, SENSE_MIDDLE_ONLY,  32'd240, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_OUTER_ONLY,   32'd250, 16'd0);
        queue_sample(1'b1, 1'b1, SENSE_ALL_BLACK,    32'd260, 16'd100);   // obstacle stop
        queue_sample(1'b0, 1'b1, SENSE_ALL_WHITE,    32'd270, 16'hFFFF);  // already stopped
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'd280, 16'd0);     // restart mid-lap
        queue_sample(1'b1, 1'b0, SENSE_ALL_WHITE,    32'd290, 16'd0);     // stopped > lap
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'hFFFF_FFF0, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_ALL_WHITE,    32'hFFFF_FFF0, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'hFFFF_FFF0, 16'd0);
        queue_sample(1'b1, 1'b0, SENSE_ALL_WHITE,    32'hFFFF_FFF0, 16'd0);  // zero-length lap
        queue_sample(1'b1, 1'b0, SENSE_ALL_BLACK,    32'hFFFF_FFFF, 16'hFFFF);
        queue_sample(1'b1, 1'b0, SENSE_ALL_WHITE,    32'h0000_0020, 16'd0);  // tick wraps
        wait_idle();

        // Same setting, random track; stop feeding halfway until all results drain.
        queue_track(150);
        wait_idle();
        queue_track(150);
        wait_idle();

        // Everything at full scale, with no idling on either side.
        apply_setting('1, '1, '1, '1, '1, '1, '1, '1);
        steady_flow = 1'b1;
        queue_track(250);
        wait_idle();
        steady_flow = 1'b0;

        // Everything at zero: amounts left over get clamped to a zero limit.
        apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
        queue_track(250);
        wait_idle();

        // A few random settings; limits may fall below the carried amounts.
        repeat (3) begin
            apply_setting(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 200)),
                          CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 2000)),
                          CFG_W'($urandom_range(0, 8000)), CFG_W'($urandom_range(0, 8000)),
                          CFG_W'($urandom), CFG_W'($urandom));
            queue_track(250);
            wait_idle();
        end

        $display("Checked %0d sensor samples over %0d register settings (%0d writes)",
                 samples_taken, settings_used, cfg_writes);
        $display("Seen %0d lap reports, %0d starts, %0d stops, %0d veer commands",
                 lap_reports, start_cmds, stop_cmds, veer_cmds);
        if (mismatch_cnt == 0 && expected_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
